// ----- rtl/chfh_pkg.sv -----
// Shared types, constants and helpers for the case-folded substring hit finder.
`timescale 1ns / 1ps
`default_nettype none

package chfh_pkg;

	// Window and needle geometry
	localparam int NEEDLE_MAX = 16;
	localparam int LEN_W      = $clog2(NEEDLE_MAX + 1);
	localparam int AGE_W      = $clog2(NEEDLE_MAX);

	// Position counters: line saturates one above the column limit
	localparam int POS_W          = 21;
	localparam int FILE_MAX_BYTES = 1 << 20;
	localparam logic [POS_W-1:0] LINE_LIMIT = POS_W'(FILE_MAX_BYTES + 1);
	localparam logic [POS_W-1:0] COL_LIMIT  = POS_W'(FILE_MAX_BYTES);
	localparam logic [POS_W-1:0] POS_ONE    = POS_W'(1);

	localparam logic [7:0] NEWLINE = 8'h0a;

	localparam int CFG_DATA_W  = 64;
	localparam int CFG_INDEX_W = 3;
	localparam int HITS_W      = 16;
	localparam logic [HITS_W-1:0] MAX_HITS_RESET = HITS_W'(1000);

	// Configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_NEEDLE_LOW  = 3'd0,
		REG_NEEDLE_HIGH = 3'd1,
		REG_NEEDLE_LEN  = 3'd2,
		REG_MAX_HITS    = 3'd3,
		REG_EVERY_OCC   = 3'd4
	} cfg_reg_t;

	// Contents of one window cell
	typedef struct packed {
		logic             valid;
		logic [7:0]       ch;
		logic [POS_W-1:0] line;
		logic [POS_W-1:0] col;
	} cell_data_t;

	// Per-cell compare results
	typedef struct packed {
		logic eq;
		logic nl;
	} cell_flag_t;

	// Decision for the word in the compare stage
	typedef struct packed {
		logic hit;
		logic trunc;
	} hit_info_t;

	// ASCII upper to lower case
	function automatic logic [7:0] fold(input logic [7:0] b);
		if (b >= 8'h41 && b <= 8'h5a) begin
			return b + 8'h20;
		end
		return b;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/chfh_cell.sv -----
// One window cell: holds a byte with its line and column and compares it to its needle byte.
`timescale 1ns / 1ps
`default_nettype none

module chfh_cell
	import chfh_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       shift,
	input  wire logic       kill,
	input  wire cell_data_t d,
	input  wire logic [7:0] needle_ch,
	output cell_data_t      q,
	output cell_flag_t      flag
);

	logic             valid_q;
	logic [7:0]       ch_q;
	logic [POS_W-1:0] line_q;
	logic [POS_W-1:0] col_q;

	// valid bit; a new file drops everything older than its first byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= d.valid & ~kill;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (shift) begin
			ch_q   <= d.ch;
			line_q <= d.line;
			col_q  <= d.col;
		end
	end

	assign q       = '{valid: valid_q, ch: ch_q, line: line_q, col: col_q};
	assign flag.eq = (ch_q == needle_ch);
	assign flag.nl = (ch_q == NEWLINE);

endmodule

`default_nettype wire

// ----- rtl/chfh_match.sv -----
// Match decision, suppression tracking and hit counting for the word in the compare stage.
`timescale 1ns / 1ps
`default_nettype none

module chfh_match
	import chfh_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  fire,
	input  wire logic                  start,
	input  wire logic [7:0]            newest,
	input  wire logic [LEN_W-1:0]      len,
	input  wire logic                  every,
	input  wire logic [HITS_W-1:0]     max_hits,
	input  wire cell_flag_t            flags [NEEDLE_MAX],
	input  wire logic [NEEDLE_MAX-1:0] valid_vec,
	output hit_info_t                  info
);

	logic [LEN_W-1:0]  ob_q, ob, ob_n;
	logic              wn_q, wn, wn_n;
	logic [HITS_W-1:0] hits_q, hits_inc;
	logic              stopped_q;
	logic [LEN_W-1:0]  len_m1;
	logic [NEEDLE_MAX-1:0] in_use, eq_ok;
	logic              all_eq, full, match, blocked, hit, trunc;
	logic              found;
	logic [AGE_W-1:0]  nl_age;

	assign len_m1 = len - LEN_W'(1);

	// cells that take part in the compare, oldest used one is age len-1
	always_comb begin
		for (int k = 0; k < NEEDLE_MAX; k++) begin
			in_use[k] = (LEN_W'(k) < len);
			eq_ok[k]  = flags[k].eq | ~in_use[k];
		end
	end

	assign all_eq = &eq_ok;
	assign full   = valid_vec[len_m1[AGE_W-1:0]];
	assign match  = (len != '0) && full && all_eq;

	// first newline from the match start is the oldest used cell holding one
	always_comb begin
		found  = 1'b0;
		nl_age = '0;
		for (int k = 0; k < NEEDLE_MAX; k++) begin
			if (in_use[k] && flags[k].nl) begin
				found  = 1'b1;
				nl_age = AGE_W'(k);
			end
		end
	end

	// suppression as seen by this word; a new file clears it
	assign ob      = start ? '0 : ob_q;
	assign wn      = start ? 1'b0 : wn_q;
	assign blocked = wn || (ob != '0);

	assign hit      = match && !blocked && !stopped_q;
	assign hits_inc = hits_q + HITS_W'(1);
	assign trunc    = (hits_inc >= max_hits);

	// next suppression state; an empty needle leaves no overlap window
	always_comb begin
		ob_n = (ob != '0) ? ob - LEN_W'(1) : '0;
		wn_n = wn;
		if (wn && newest == NEWLINE) begin
			wn_n = 1'b0;
			ob_n = (len != '0) ? len_m1 : '0;
		end
		if (hit) begin
			if (every) begin
				ob_n = len_m1;
			end else if (found) begin
				ob_n = len_m1 - LEN_W'(nl_age);
			end else begin
				ob_n = '0;
				wn_n = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_q      <= '0;
			wn_q      <= 1'b0;
			hits_q    <= '0;
			stopped_q <= 1'b0;
		end else if (fire) begin
			ob_q <= ob_n;
			wn_q <= wn_n;
			if (hit) begin
				hits_q <= hits_inc;
				if (trunc) begin
					stopped_q <= 1'b1;
				end
			end
		end
	end

	assign info.hit   = hit;
	assign info.trunc = trunc;

endmodule

`default_nettype wire

// ----- rtl/case_folded_substring_hit_finder.sv -----
// Top level of the case-folded substring hit finder: input counters, cell chain, output register.
//
//   channel | handshake             | word
//   --------+-----------------------+----------------------------------------------
//   byte    | byte_valid/byte_ready | data_byte, file_start, file_tag
//   hit     | hit_valid/hit_ready   | hit_file, hit_line, hit_column, truncated
//   cfg     | cfg_we (no wait)      | cfg_index, cfg_data
//
// One byte per cycle sustained while no hit is stalled. A byte shifts into the cell chain
// on acceptance and is compared from the cell registers; a hit enters the output register
// when the compare stage moves on. Reset clears valid bits, counters and suppression;
// no clearing pass. A stalled hit holds the compare stage, which holds the chain; a byte
// is still taken while the compare stage is empty or moving on.
`timescale 1ns / 1ps
`default_nettype none

module case_folded_substring_hit_finder
	import chfh_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   byte_valid,
	output logic                        byte_ready,
	input  wire logic [7:0]             data_byte,
	input  wire logic                   file_start,
	input  wire logic [15:0]            file_tag,
	output logic                        hit_valid,
	input  wire logic                   hit_ready,
	output logic [15:0]                 hit_file,
	output logic [POS_W-1:0]            hit_line,
	output logic [POS_W-1:0]            hit_column,
	output logic                        truncated,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	// configuration registers
	logic [63:0]       needle_low_q, needle_high_q;
	logic [4:0]        needle_len_q;
	logic [HITS_W-1:0] max_hits_q;
	logic              every_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needle_low_q  <= '0;
			needle_high_q <= '0;
			needle_len_q  <= '0;
			max_hits_q    <= MAX_HITS_RESET;
			every_q       <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_NEEDLE_LOW:  needle_low_q  <= cfg_data;
				REG_NEEDLE_HIGH: needle_high_q <= cfg_data;
				REG_NEEDLE_LEN:  needle_len_q  <= cfg_data[4:0];
				REG_MAX_HITS:    max_hits_q    <= cfg_data[HITS_W-1:0];
				REG_EVERY_OCC:   every_q       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// clamped length and folded needle bytes
	logic [LEN_W-1:0] len, len_m1;
	logic [127:0]     needle_all;
	logic [7:0]       needle_arr [NEEDLE_MAX];
	logic [7:0]       aligned    [NEEDLE_MAX];

	assign len    = (needle_len_q > 5'(NEEDLE_MAX)) ? LEN_W'(NEEDLE_MAX) : LEN_W'(needle_len_q);
	assign len_m1 = len - LEN_W'(1);

	assign needle_all = {needle_high_q, needle_low_q};

	always_comb begin
		for (int i = 0; i < NEEDLE_MAX; i++) begin
			needle_arr[i] = fold(needle_all[8*i +: 8]);
		end
	end

	// cell at age k holds the needle byte at len-1-k
	always_comb begin
		logic [LEN_W-1:0] idx;
		for (int k = 0; k < NEEDLE_MAX; k++) begin
			idx        = len_m1 - LEN_W'(k);
			aligned[k] = needle_arr[idx[AGE_W-1:0]];
		end
	end

	// flow control
	logic v_s1, start_s1, fire, accept;
	logic [15:0] tag_s1;
	hit_info_t   info;

	assign fire       = v_s1 && (!hit_valid || hit_ready);
	assign byte_ready = !v_s1 || fire;
	assign accept     = byte_valid && byte_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (fire) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			start_s1 <= file_start;
			tag_s1   <= file_tag;
		end
	end

	// line and column of the incoming byte
	logic [POS_W-1:0] line_q, col_q, cur_line, cur_col;
	logic [7:0]       in_ch;

	assign in_ch    = fold(data_byte);
	assign cur_line = file_start ? POS_ONE : line_q;
	assign cur_col  = file_start ? POS_ONE : col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= POS_ONE;
			col_q  <= POS_ONE;
		end else if (accept) begin
			if (in_ch == NEWLINE) begin
				line_q <= (cur_line < LINE_LIMIT) ? cur_line + POS_ONE : cur_line;
				col_q  <= POS_ONE;
			end else begin
				line_q <= cur_line;
				col_q  <= (cur_col < COL_LIMIT) ? cur_col + POS_ONE : cur_col;
			end
		end
	end

	// cell chain, age 0 is the newest byte
	cell_data_t            cell_in  [NEEDLE_MAX];
	cell_data_t            cell_q   [NEEDLE_MAX];
	cell_flag_t            cell_flg [NEEDLE_MAX];
	logic [NEEDLE_MAX-1:0] valid_vec;

	assign cell_in[0] = '{valid: 1'b1, ch: in_ch, line: cur_line, col: cur_col};

	for (genvar k = 0; k < NEEDLE_MAX; k++) begin : g_cell
		if (k > 0) begin : g_link
			assign cell_in[k] = cell_q[k-1];
		end
		chfh_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift     (accept),
			.kill      ((k > 0) ? file_start : 1'b0),
			.d         (cell_in[k]),
			.needle_ch (aligned[k]),
			.q         (cell_q[k]),
			.flag      (cell_flg[k])
		);
		assign valid_vec[k] = cell_q[k].valid;
	end

	// compare and suppression
	chfh_match u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.start     (start_s1),
		.newest    (cell_q[0].ch),
		.len       (len),
		.every     (every_q),
		.max_hits  (max_hits_q),
		.flags     (cell_flg),
		.valid_vec (valid_vec),
		.info      (info)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_valid <= 1'b0;
		end else if (fire && info.hit) begin
			hit_valid <= 1'b1;
		end else if (hit_ready) begin
			hit_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && info.hit) begin
			hit_file   <= tag_s1;
			hit_line   <= cell_q[len_m1[AGE_W-1:0]].line;
			hit_column <= cell_q[len_m1[AGE_W-1:0]].col;
			truncated  <= info.trunc;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/chfh_checker.sv -----
// Port-level checks for the hit finder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module chfh_checker
	import chfh_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   byte_valid,
	input wire logic                   byte_ready,
	input wire logic [7:0]             data_byte,
	input wire logic                   file_start,
	input wire logic [15:0]            file_tag,
	input wire logic                   hit_valid,
	input wire logic                   hit_ready,
	input wire logic [15:0]            hit_file,
	input wire logic [POS_W-1:0]       hit_line,
	input wire logic [POS_W-1:0]       hit_column,
	input wire logic                   truncated,
	input wire logic                   cfg_we,
	input wire logic [CFG_INDEX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0]  cfg_data
);

	// a stalled hit word holds
	a_hit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hit_valid && !hit_ready |=> hit_valid && $stable(hit_file) && $stable(hit_line)
			&& $stable(hit_column) && $stable(truncated))
		else $error("hit word changed while stalled");

	// input only stalls behind a waiting hit
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!byte_ready |-> hit_valid && !hit_ready)
		else $error("byte channel stalled without a waiting hit");

	// positions are one-based
	a_pos_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		hit_valid |-> hit_line != '0 && hit_column != '0)
		else $error("hit position is zero");

	// nothing follows a truncated hit
	a_stop: assert property (@(posedge clk) disable iff (!arst_n)
		hit_valid && hit_ready && truncated |=> !hit_valid)
		else $error("hit after truncation");

endmodule

bind case_folded_substring_hit_finder chfh_checker u_chfh_checker (.*);

`default_nettype wire

// ----- dv/case_folded_substring_hit_finder_test.sv -----
// Self-checking testbench for the case-folded substring hit finder: scoreboard class and top.
`timescale 1ns / 1ps

import chfh_pkg::*;

// Mirrors the hit finder state and keeps the hits still owed by the block
class hit_ledger;
	typedef struct {
		logic [15:0]      file;
		logic [POS_W-1:0] line;
		logic [POS_W-1:0] column;
		logic             trunc;
	} hit_word_t;

	hit_word_t pending_hits[$];

	// register copies
	logic [63:0] needle_lo;
	logic [63:0] needle_hi;
	logic [4:0]  needle_len;
	logic [15:0] hit_limit;
	logic        every_occ;

	// sliding window of folded bytes and their positions
	logic [7:0]       win_ch[NEEDLE_MAX];
	logic [POS_W-1:0] win_line[NEEDLE_MAX];
	logic [POS_W-1:0] win_col[NEEDLE_MAX];
	int               fill;
	logic [POS_W-1:0] line_no;
	logic [POS_W-1:0] col_no;
	int               skip_left;
	bit               await_nl;
	logic [15:0]      hit_count;
	bit               halted;

	int mismatches;
	int hits_seen;
	bit trunc_seen;

	function new();
		needle_lo  = '0;
		needle_hi  = '0;
		needle_len = '0;
		hit_limit  = MAX_HITS_RESET;
		every_occ  = 1'b0;
		clear_file();
		hit_count  = '0;
		halted     = 0;
		mismatches = 0;
		hits_seen  = 0;
		trunc_seen = 0;
	endfunction

	function void clear_file();
		for (int i = 0; i < NEEDLE_MAX; i++) begin
			win_ch[i]   = '0;
			win_line[i] = '0;
			win_col[i]  = '0;
		end
		fill      = 0;
		line_no   = POS_ONE;
		col_no    = POS_ONE;
		skip_left = 0;
		await_nl  = 0;
	endfunction

	function void write_reg(cfg_reg_t idx, logic [63:0] v);
		case (idx)
			REG_NEEDLE_LOW:  needle_lo  = v;
			REG_NEEDLE_HIGH: needle_hi  = v;
			REG_NEEDLE_LEN:  needle_len = v[4:0];
			REG_MAX_HITS:    hit_limit  = v[15:0];
			REG_EVERY_OCC:   every_occ  = v[0];
			default: ;
		endcase
	endfunction

	function logic [7:0] lower_ascii(logic [7:0] b);
		if (b >= 8'h41 && b <= 8'h5a) begin
			return b + 8'h20;
		end
		return b;
	endfunction

	// needle byte as compared, folded like the text
	function logic [7:0] needle_at(int i);
		if (i < 8) begin
			return lower_ascii(needle_lo[8*i +: 8]);
		end
		if (i < 16) begin
			return lower_ascii(needle_hi[8*(i-8) +: 8]);
		end
		return 8'h00;
	endfunction

	// length in use, clamped to the window
	function int eff_len();
		return (needle_len > NEEDLE_MAX) ? NEEDLE_MAX : int'(needle_len);
	endfunction

	// One accepted word: advance the window, queue a hit if one is due
	function void take_byte(logic [7:0] raw, logic first, logic [15:0] tag);
		logic [7:0] b;
		int         len;
		int         base;
		bit         blocked;
		bit         match;
		bit         found;
		hit_word_t  w;

		b   = lower_ascii(raw);
		len = eff_len();
		if (first) begin
			clear_file();
		end

		for (int i = 0; i < NEEDLE_MAX - 1; i++) begin
			win_ch[i]   = win_ch[i+1];
			win_line[i] = win_line[i+1];
			win_col[i]  = win_col[i+1];
		end
		win_ch[NEEDLE_MAX-1]   = b;
		win_line[NEEDLE_MAX-1] = line_no;
		win_col[NEEDLE_MAX-1]  = col_no;
		if (fill < NEEDLE_MAX) begin
			fill++;
		end

		// saturating position counters
		if (b == NEWLINE) begin
			if (line_no < LINE_LIMIT) begin
				line_no++;
			end
			col_no = POS_ONE;
		end else if (col_no < COL_LIMIT) begin
			col_no++;
		end

		// suppression from earlier hits
		blocked = await_nl || skip_left != 0;
		if (skip_left != 0) begin
			skip_left--;
		end
		if (await_nl && b == NEWLINE) begin
			await_nl  = 0;
			skip_left = (len > 0) ? len - 1 : 0;
		end

		base  = NEEDLE_MAX - len;
		match = len > 0 && fill >= len;
		for (int i = 0; i < len; i++) begin
			if (win_ch[base+i] != needle_at(i)) begin
				match = 0;
			end
		end
		if (!match || blocked || halted) begin
			return;
		end

		hit_count++;
		w.file   = tag;
		w.line   = win_line[base];
		w.column = win_col[base];
		w.trunc  = hit_count >= hit_limit;
		if (w.trunc) begin
			halted = 1;
		end
		pending_hits.insert(pending_hits.size(), w);

		// set up suppression for later matches
		if (every_occ) begin
			skip_left = len - 1;
		end else begin
			found = 0;
			for (int i = 0; i < len && !found; i++) begin
				if (win_ch[base+i] == NEWLINE) begin
					skip_left = i;
					found     = 1;
				end
			end
			if (!found) begin
				skip_left = 0;
				await_nl  = 1;
			end
		end
	endfunction

	// One accepted hit word against the oldest one owed
	function void check_hit(logic [15:0] file, logic [POS_W-1:0] line,
			logic [POS_W-1:0] column, logic trunc);
		hit_word_t w;

		if (pending_hits.size() == 0) begin
			$error("unexpected hit: file %0d line %0d column %0d truncated %0d",
				file, line, column, trunc);
			mismatches++;
			return;
		end
		w = pending_hits.pop_front();
		hits_seen++;
		if (trunc === 1'b1) begin
			trunc_seen = 1;
		end
		if (file !== w.file) begin
			$error("hit_file: expected %0d, actual %0d", w.file, file);
			mismatches++;
		end
		if (line !== w.line) begin
			$error("hit_line: expected %0d, actual %0d", w.line, line);
			mismatches++;
		end
		if (column !== w.column) begin
			$error("hit_column: expected %0d, actual %0d", w.column, column);
			mismatches++;
		end
		if (trunc !== w.trunc) begin
			$error("truncated: expected %0d, actual %0d", w.trunc, trunc);
			mismatches++;
		end
	endfunction
endclass

module case_folded_substring_hit_finder_test;
	import chfh_pkg::*;

	localparam int TARGET_BYTES = 1750;
	localparam int CLOSING_BYTES = 150;
	localparam int STALL_LIMIT = 2000;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  byte_valid;
	logic                  byte_ready;
	logic [7:0]            data_byte;
	logic                  file_start;
	logic [15:0]           file_tag;
	logic                  hit_valid;
	logic                  hit_ready;
	logic [15:0]           hit_file;
	logic [POS_W-1:0]      hit_line;
	logic [POS_W-1:0]      hit_column;
	logic                  truncated;
	logic                  cfg_we;
	cfg_reg_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	hit_ledger ledger = new();

	int bytes_sent = 0;
	int settings_used = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	bit quiet = 0;
	int idle_cycles = 0;
	int stall_left = 0;

	case_folded_substring_hit_finder i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.data_byte  (data_byte),
		.file_start (file_start),
		.file_tag   (file_tag),
		.hit_valid  (hit_valid),
		.hit_ready  (hit_ready),
		.hit_file   (hit_file),
		.hit_line   (hit_line),
		.hit_column (hit_column),
		.truncated  (truncated),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #6 clk = ~clk;

	// Hit side: check accepted words, stall in random bursts
	always @(posedge clk) begin
		if (arst_n) begin
			if (hit_valid && hit_ready) begin
				ledger.check_hit(hit_file, hit_line, hit_column, truncated);
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				hit_ready  <= 1'b0;
			end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
				stall_left <= $urandom_range(1, 10) - 1;
				hit_ready  <= 1'b0;
			end else begin
				hit_ready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles with no word moving on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_valid && byte_ready) || (hit_valid && hit_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	function automatic logic [7:0] mixed_case(logic [7:0] c);
		if (c >= 8'h61 && c <= 8'h7a && $urandom_range(0, 1) == 1) begin
			return c - 8'h20;
		end
		return c;
	endfunction

	// Needle bytes from a small alphabet, with newlines and raw bytes mixed in
	function automatic logic [7:0] pick_needle_byte();
		int r;

		r = $urandom_range(0, 9);
		if (r == 0) begin
			return NEWLINE;
		end
		if (r == 1) begin
			return 8'($urandom);
		end
		if (r < 5) begin
			return 8'h41 + 8'($urandom_range(0, 3));
		end
		return 8'h61 + 8'($urandom_range(0, 3));
	endfunction

	// Present one word on the byte channel and wait until it is taken
	task automatic push_byte(input logic [7:0] b, input logic first, input logic [15:0] tag);
		if (!quiet && $urandom_range(0, 99) < idle_pct) begin
			byte_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		byte_valid <= 1'b1;
		data_byte  <= b;
		file_start <= first;
		file_tag   <= tag;
		@(posedge clk);
		while (!byte_ready) @(posedge clk);
		ledger.take_byte(b, first, tag);
		bytes_sent++;
	endtask

	task automatic send_text(input string s, input logic [15:0] tag);
		for (int i = 0; i < s.len(); i++) begin
			push_byte(s[i], i == 0, tag);
		end
	endtask

	// Stop sending, let every owed hit arrive and the pipeline empty
	task automatic settle();
		byte_valid <= 1'b0;
		while (ledger.pending_hits.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [63:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		ledger.write_reg(idx, v);
	endtask

	// All five registers back to back, write enable held high throughout
	task automatic apply_config(input logic [63:0] lo, input logic [63:0] hi,
			input logic [4:0] len, input logic [15:0] max_hits, input logic every);
		write_reg(REG_NEEDLE_LOW, lo);
		write_reg(REG_NEEDLE_HIGH, hi);
		write_reg(REG_NEEDLE_LEN, 64'(len));
		write_reg(REG_MAX_HITS, 64'(max_hits));
		write_reg(REG_EVERY_OCC, 64'(every));
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// One file: planted needles in random case, broken prefixes, filler and noise
	task automatic random_file(input int n_bytes);
		logic [15:0] tag;
		logic [7:0]  c;
		int          len;
		int          k;
		int          r;
		int          part;

		tag = 16'($urandom);
		len = ledger.eff_len();
		k   = 0;
		while (k < n_bytes) begin
			r = $urandom_range(0, 99);
			if (len > 0 && r < 25) begin
				part = (r < 19) ? len : $urandom_range(1, len);
				for (int i = 0; i < part; i++) begin
					push_byte(mixed_case(ledger.needle_at(i)), k == 0, tag);
					k++;
				end
			end else begin
				if (r < 40) begin
					c = NEWLINE;
				end else if (r < 90) begin
					c = mixed_case(8'h61 + 8'($urandom_range(0, 3)));
				end else begin
					c = 8'($urandom);
				end
				push_byte(c, k == 0, tag);
				k++;
			end
		end
	endtask

	// One setting of the registers followed by a run of random files
	task automatic run_phase(input int p, input int n_bytes, input bit closing);
		logic [127:0] nb;
		logic [7:0]   rep;
		bit           repeated;
		logic [4:0]   len;
		logic [15:0]  max_hits;
		logic         every;
		int           sent0;

		settle();
		repeated = ($urandom_range(0, 4) == 0);
		rep      = pick_needle_byte();
		for (int i = 0; i < 16; i++) begin
			nb[8*i +: 8] = repeated ? rep : pick_needle_byte();
		end

		// extremes of the length first, then mostly short needles
		if (p == 0) begin
			len = 5'd16;
		end else if (p == 1) begin
			len = 5'd0;
		end else if (p == 2) begin
			len = 5'($urandom_range(17, 31));
		end else if ($urandom_range(0, 3) == 0) begin
			len = 5'($urandom_range(7, 16));
		end else begin
			len = 5'($urandom_range(1, 6));
		end
		every = (p < 2) ? p[0] : 1'($urandom_range(0, 1));

		// hit limit out of reach until the closing phase forces a stop
		if (closing) begin
			case ($urandom_range(0, 2))
				0: max_hits = 16'd0;
				1: max_hits = 16'd1;
				default: max_hits = ledger.hit_count + 16'($urandom_range(1, 5));
			endcase
		end else if (p == 1) begin
			max_hits = 16'hffff;
		end else begin
			max_hits = 16'($urandom_range(2000, 65535));
		end

		apply_config(nb[63:0], nb[127:64], len, max_hits, every);
		idle_pct  = 15 * $urandom_range(0, 2);
		stall_pct = 15 * $urandom_range(0, 2);
		quiet     = closing;
		sent0     = bytes_sent;
		while (bytes_sent - sent0 < n_bytes) begin
			random_file($urandom_range(12, 70));
		end
	endtask

	initial begin
		int p;

		arst_n     = 1'b0;
		byte_valid = 1'b0;
		data_byte  = '0;
		file_start = 1'b0;
		file_tag   = '0;
		hit_ready  = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = REG_NEEDLE_LOW;
		cfg_data   = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty needle after reset: nothing may hit
		push_byte(8'h00, 1'b1, 16'hffff);
		push_byte(8'hff, 1'b0, 16'hffff);
		push_byte(8'h41, 1'b0, 16'hffff);

		// mixed-case needle register, first match per line only
		settle();
		apply_config(64'h4261, 64'h0, 5'd2, MAX_HITS_RESET, 1'b0);
		send_text("ab\nAB ab", 16'h0000);

		// self-overlapping needle, every occurrence
		settle();
		apply_config(64'h6161, 64'h0, 5'd2, MAX_HITS_RESET, 1'b1);
		send_text("aaAaa", 16'h1234);

		// newline inside the matched bytes ends suppression there
		settle();
		apply_config(64'h630a62, 64'h0, 5'd3, MAX_HITS_RESET, 1'b0);
		send_text("ab\ncb\nc", 16'h8001);

		// random settings, then a closing phase without idling that stops the search
		p = 0;
		while (bytes_sent < TARGET_BYTES - CLOSING_BYTES) begin
			run_phase(p, $urandom_range(60, 180), 1'b0);
			p++;
		end
		run_phase(p, CLOSING_BYTES, 1'b1);

		settle();
		repeat (8) @(posedge clk);
		if (ledger.pending_hits.size() != 0) begin
			$error("%0d expected hits never arrived", ledger.pending_hits.size());
		end
		$display("Sent %0d bytes under %0d register settings; %0d hits checked.",
			bytes_sent, settings_used, ledger.hits_seen);
		$display("Hit limit stop %0s.", ledger.trunc_seen ? "reached" : "not reached");
		if (ledger.mismatches == 0 && ledger.pending_hits.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
